@@ hw/rtl/ssrq_pkg.sv @@
// ssrq_pkg: shared constants and types for the sorted store rank query block.
// Used by ssrq_front, ssrq_back and sorted_store_rank_query. No dependencies.
`default_nettype none

package ssrq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [KEY_W-1:0] SIGN_BIAS = 32'h8000_0000;

    typedef enum logic [0:0] {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    // queued beat: request kind and order-preserving unsigned key
    typedef struct packed {
        req_t             kind;
        logic [KEY_W-1:0] key;
    } sq_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_SHIFT,
        ST_DRAIN,
        ST_PLACE,
        ST_DONE
    } back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/ssrq_front.sv @@
// ssrq_front: input acceptance, key mapping and a two-entry queue.
// Depends on ssrq_pkg.
`default_nettype none

module ssrq_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    input  wire logic signed [ssrq_pkg::KEY_W-1:0] value,
    output logic                               q_valid,
    output ssrq_pkg::sq_item_t                 q_item,
    input  wire logic                          q_pop
);
    import ssrq_pkg::*;

    sq_item_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;
    logic                push;
    logic                pop;
    sq_item_t            new_item;

    assign in_stall = (cnt_reg == QCNT_W'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.kind = req_t'(req_type);
        new_item.key  = unsigned'(value) ^ SIGN_BIAS;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ssrq_back.sv @@
// ssrq_back: sorted table memory, binary search, insertion shift and result register.
// Depends on ssrq_pkg.
`default_nettype none

module ssrq_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire ssrq_pkg::sq_item_t            q_item,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ssrq_pkg::COUNT_W-1:0]       count,
    output logic                               dropped
);
    import ssrq_pkg::*;

    logic [KEY_W-1:0]   mem [CAPACITY];
    logic [KEY_W-1:0]   rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [KEY_W-1:0]   wr_data;

    back_state_t        state_reg,   state_next;
    sq_item_t           item_reg,    item_next;
    logic [COUNT_W-1:0] lo_reg,      lo_next;
    logic [COUNT_W-1:0] hi_reg,      hi_next;
    logic [ADDR_W-1:0]  mid_reg,     mid_next;
    logic [COUNT_W-1:0] occ_reg,     occ_next;
    logic [COUNT_W-1:0] ptr_reg,     ptr_next;
    logic [ADDR_W-1:0]  dst_reg,     dst_next;
    logic               pend_reg,    pend_next;
    logic [COUNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic               res_drp_reg, res_drp_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_cnt_reg,   out_cnt_next;
    logic               out_drp_reg,   out_drp_next;

    logic [COUNT_W-1:0] mid_full;
    logic [COUNT_W-1:0] src;

    assign out_valid = out_valid_reg;
    assign count     = out_cnt_reg;
    assign dropped   = out_drp_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        occ_next       = occ_reg;
        ptr_next       = ptr_reg;
        dst_next       = dst_reg;
        pend_next      = pend_reg;
        res_cnt_next   = res_cnt_reg;
        res_drp_next   = res_drp_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_cnt_next   = out_cnt_reg;
        out_drp_next   = out_drp_reg;
        q_pop          = 1'b0;
        rd_addr        = mid_reg;
        wr_en          = 1'b0;
        wr_addr        = dst_reg;
        wr_data        = rd_data_reg;
        mid_full       = lo_reg + ((hi_reg - lo_reg) >> 1);
        src            = ptr_reg - COUNT_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    lo_next   = '0;
                    hi_next   = occ_reg;
                    if (q_item.kind == REQ_LOAD && occ_reg == COUNT_W'(CAPACITY))
                    begin
                        res_cnt_next = occ_reg;
                        res_drp_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr    = mid_full[ADDR_W-1:0];
                    mid_next   = mid_full[ADDR_W-1:0];
                    state_next = ST_CMP;
                end
                else if (item_reg.kind == REQ_QUERY)
                begin
                    res_cnt_next = lo_reg;
                    res_drp_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    ptr_next   = occ_reg;
                    pend_next  = 1'b0;
                    state_next = (occ_reg == lo_reg) ? ST_PLACE : ST_SHIFT;
                end
            end
            ST_CMP:
            begin
                if (rd_data_reg <= item_reg.key)
                begin
                    lo_next = COUNT_W'(mid_reg) + COUNT_W'(1);
                end
                else
                begin
                    hi_next = COUNT_W'(mid_reg);
                end
                state_next = ST_PROBE;
            end
            ST_SHIFT:
            begin
                // read one below, write the previous read one slot up
                rd_addr   = src[ADDR_W-1:0];
                wr_en     = pend_reg;
                dst_next  = ptr_reg[ADDR_W-1:0];
                pend_next = 1'b1;
                ptr_next  = src;
                if (src == lo_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                wr_en      = 1'b1;
                state_next = ST_PLACE;
            end
            ST_PLACE:
            begin
                wr_en        = 1'b1;
                wr_addr      = lo_reg[ADDR_W-1:0];
                wr_data      = item_reg.key;
                occ_next     = occ_reg + COUNT_W'(1);
                res_cnt_next = occ_reg + COUNT_W'(1);
                res_drp_next = 1'b0;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_cnt_next   = res_cnt_reg;
                    out_drp_next   = res_drp_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        ptr_reg     <= ptr_next;
        dst_reg     <= dst_next;
        res_cnt_reg <= res_cnt_next;
        res_drp_reg <= res_drp_next;
        out_cnt_reg <= out_cnt_next;
        out_drp_reg <= out_drp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_store_rank_query.sv @@
// sorted_store_rank_query: top level, front queue plus search/insert back end.
// Depends on ssrq_pkg, ssrq_front and ssrq_back.
//
// Input channel (in_valid/in_stall): req_type 0 inserts value into an ascending
// table of up to 1024 signed entries, req_type 1 asks how many stored values
// are <= value. Every input beat yields exactly one output beat, in order.
// Output channel (out_valid/out_stall): count is the rank for a query, or the
// occupancy after a load; dropped flags a load refused because the table is full.
// The back end does a binary search over a single-port table memory; each probe
// passes through ST_PROBE and then ST_CMP. A load then moves each entry above
// the insert position one slot up in ST_SHIFT, passes ST_DRAIN (skipped when
// nothing moves) and writes the key in ST_PLACE; a full-table load goes to ST_DONE.
// One item is worked on at a time.
// A two-beat queue sits in front, so inputs are taken while the back end works
// or while a finished result waits on out_stall; in_stall rises when it fills.
// A stalled result holds in the output register; the next result waits in ST_DONE.
// Reset empties the table (occupancy 0), the queue and the output register.
`default_nettype none

module sorted_store_rank_query (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              req_type,
    input  wire logic signed [ssrq_pkg::KEY_W-1:0] value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [ssrq_pkg::COUNT_W-1:0]           count,
    output logic                                   dropped
);
    import ssrq_pkg::*;

    logic     q_valid;
    logic     q_pop;
    sq_item_t q_item;

    ssrq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .value    (value),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ssrq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .count     (count),
        .dropped   (dropped)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped) |-> (count == COUNT_W'(CAPACITY)))
        else $error("drop flagged with table not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("input stall rose without an accepted beat");

endmodule

`default_nettype wire

@@ test/sorted_store_rank_query_test.sv @@
`timescale 1ns / 100ps
// Testbench for sorted_store_rank_query: directed table then random load/query beats,
// every result checked against fixed values or a sorted-table model. Depends on ssrq_pkg and the DUT.

module sorted_store_rank_query_test;

    import ssrq_pkg::*;

    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int RAND_ITEMS  = 1080;
    localparam logic signed [KEY_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic               drp;
    } rank_result_t;

    typedef struct packed {
        req_t                    kind;
        logic signed [KEY_W-1:0] val;
        logic                    typed;
        logic [COUNT_W-1:0]      cnt;
        logic                    drp;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic                         req_type;
    logic signed [KEY_W-1:0]      value;
    logic                         out_valid;
    logic                         out_stall;
    logic [COUNT_W-1:0]           count;
    logic                         dropped;

    int           rank_table[$];
    rank_result_t pending_results[$];
    int           mismatch_total = 0;
    int           result_total   = 0;
    int           load_total     = 0;
    int           query_total    = 0;
    int           drop_total     = 0;
    int           cycle_count    = 0;
    bit           calm           = 1'b0;
    logic signed [KEY_W-1:0] ramp_value = -32'sd1000000;

    stim_row_t directed_rows [22] = '{
        '{REQ_QUERY, 32'sd0,    1'b1, 11'd0, 1'b0},
        '{REQ_QUERY, VAL_MAX,   1'b1, 11'd0, 1'b0},
        '{REQ_QUERY, VAL_MIN,   1'b1, 11'd0, 1'b0},
        '{REQ_LOAD,  32'sd0,    1'b1, 11'd1, 1'b0},
        '{REQ_LOAD,  VAL_MIN,   1'b1, 11'd2, 1'b0},
        '{REQ_LOAD,  VAL_MAX,   1'b1, 11'd3, 1'b0},
        '{REQ_QUERY, VAL_MIN,   1'b1, 11'd1, 1'b0},
        '{REQ_QUERY, VAL_MAX,   1'b1, 11'd3, 1'b0},
        '{REQ_QUERY, -32'sd1,   1'b0, 11'd0, 1'b0},
        '{REQ_LOAD,  32'sd5,    1'b0, 11'd0, 1'b0},
        '{REQ_LOAD,  32'sd5,    1'b0, 11'd0, 1'b0},
        '{REQ_LOAD,  32'sd5,    1'b0, 11'd0, 1'b0},
        '{REQ_QUERY, 32'sd5,    1'b0, 11'd0, 1'b0},
        '{REQ_QUERY, 32'sd4,    1'b0, 11'd0, 1'b0},
        '{REQ_QUERY, 32'sd6,    1'b0, 11'd0, 1'b0},
        '{REQ_LOAD,  -32'sd5,   1'b0, 11'd0, 1'b0},
        '{REQ_LOAD,  VAL_MAX,   1'b0, 11'd0, 1'b0},
        '{REQ_LOAD,  VAL_MIN,   1'b0, 11'd0, 1'b0},
        '{REQ_QUERY, VAL_MIN,   1'b0, 11'd0, 1'b0},
        '{REQ_QUERY, VAL_MAX-1, 1'b0, 11'd0, 1'b0},
        '{REQ_QUERY, VAL_MAX,   1'b0, 11'd0, 1'b0},
        '{REQ_QUERY, 32'sd0,    1'b0, 11'd0, 1'b0}
    };

    sorted_store_rank_query DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .count     (count),
        .dropped   (dropped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // rank model: upper-bound position, insert after equal values
    function automatic rank_result_t rank_update(req_t kind, logic signed [KEY_W-1:0] v);
        rank_result_t r;
        int pos;
        pos = 0;
        while (pos < rank_table.size() && rank_table[pos] <= int'(v))
            pos++;
        r.drp = 1'b0;
        if (kind == REQ_QUERY)
        begin
            r.cnt = COUNT_W'(pos);
            query_total++;
        end
        else if (rank_table.size() >= CAPACITY)
        begin
            r.cnt = COUNT_W'(rank_table.size());
            r.drp = 1'b1;
            drop_total++;
            load_total++;
        end
        else
        begin
            rank_table.insert(pos, int'(v));
            r.cnt = COUNT_W'(rank_table.size());
            load_total++;
        end
        return r;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_value();
        logic signed [KEY_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            1, 2: v = $signed(32'($urandom_range(0, 32))) - 32'sd16;
            3: begin
                if (rank_table.size() == 0)
                    v = 32'sd0;
                else
                    v = rank_table[$urandom_range(0, rank_table.size() - 1)]
                        + $signed(32'($urandom_range(0, 2))) - 32'sd1;
            end
            4: begin
                ramp_value = ramp_value + $signed(32'($urandom_range(1, 1000)));
                v = ramp_value;
            end
            default: v = $signed($urandom());
        endcase
        return v;
    endfunction

    // drive one input beat, wait for acceptance; returns the model's result
    task automatic send_beat(input req_t kind, input logic signed [KEY_W-1:0] v,
                             output rank_result_t r);
        while (!calm && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = rank_update(kind, v);
    endtask

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 29);
    end

    always @(posedge clk)
    begin
        rank_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            result_total++;
            if (pending_results.size() == 0)
            begin
                mismatch_total++;
                if (mismatch_total <= 10)
                    $display("unexpected result beat: count %0d dropped %0b", count, dropped);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (count !== exp_r.cnt || dropped !== exp_r.drp)
                begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("result %0d: expected count %0d dropped %0b, got count %0d dropped %0b",
                                 result_total, exp_r.cnt, exp_r.drp, count, dropped);
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rank_result_t r;
        req_t         kind;
        int           n_rand;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = 1'b0;
        value     = '0;
        out_stall = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_beat(directed_rows[i].kind, directed_rows[i].val, r);
            if (directed_rows[i].typed)
                pending_results.push_back('{directed_rows[i].cnt, directed_rows[i].drp});
            else
                pending_results.push_back(r);
        end

        n_rand = 0;
        while (n_rand < RAND_ITEMS)
        begin
            calm = (n_rand >= 400 && n_rand < 600);
            if (rank_table.size() < CAPACITY)
                kind = ($urandom_range(0, 99) < 97) ? REQ_LOAD : REQ_QUERY;
            else
                kind = ($urandom_range(0, 1) == 0) ? REQ_LOAD : REQ_QUERY;
            send_beat(kind, pick_value(), r);
            pending_results.push_back(r);
            n_rand++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("covered %0d loads (%0d refused on a full table), %0d rank queries, %0d beats",
                 load_total, drop_total, query_total, result_total);
        $display("final occupancy %0d, mismatches %0d", rank_table.size(), mismatch_total);
        if (mismatch_total == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
